[rtl/core/weo_pkg.sv]
// Shared types and constants for the wheel encoder odometry block.
// No dependencies; the RTL files refer to it by scoped names, the testbench imports it.

package weo_pkg;

  // Command queue between the decode front and the execution back
  localparam int unsigned QueueDepth = 2;
  localparam int unsigned QueuePtrW  = $clog2(QueueDepth);
  localparam int unsigned QueueCntW  = $clog2(QueueDepth + 1);

  // Serial divider: dividend is distance (16 bit) times 1000 (10 bit)
  localparam int unsigned DivBits = 26;
  localparam int unsigned DivCntW = $clog2(DivBits);
  localparam logic [DivBits-1:0] MsPerSec = DivBits'(1000);

  // Wheel field width and the number of wheels it can address
  localparam int unsigned WheelW    = 1;
  localparam int unsigned WheelSpan = 1 << WheelW;

  // Configuration reset values
  localparam logic [7:0]  DebounceRst = 8'd10;
  localparam logic [15:0] StaleRst    = 16'd900;
  localparam logic [15:0] DistanceRst = 16'd1000;
  localparam logic [2:0]  ShiftRst    = 3'd2;

  typedef enum logic [1:0] {
    CFG_DEBOUNCE = 2'd0,
    CFG_STALE    = 2'd1,
    CFG_DISTANCE = 2'd2,
    CFG_SHIFT    = 2'd3
  } cfg_idx_e;

  typedef enum logic {
    OP_PULSE = 1'b0,
    OP_READ  = 1'b1
  } op_e;

  typedef enum logic [1:0] {
    CMD_PULSE    = 2'd0,
    CMD_READ     = 2'd1,
    CMD_NO_WHEEL = 2'd2
  } cmd_kind_e;

  typedef struct packed {
    logic [7:0]  debounce_ms;
    logic [15:0] stale_ms;
    logic [15:0] distance_um;
    logic [2:0]  speed_shift;
  } cfg_t;

  typedef struct packed {
    cmd_kind_e         kind;
    logic [WheelW-1:0] wheel;
    logic [31:0]       timestamp_ms;
    logic              dir_neg;
    logic              dir_zero;
  } cmd_t;

  typedef struct packed {
    logic valid;
    logic full;
  } q_stat_t;

  typedef struct packed {
    logic               start;
    logic [DivBits-1:0] dividend;
    logic [31:0]        divisor;
  } div_req_t;

  typedef struct packed {
    logic               done;
    logic [DivBits-1:0] quotient;
  } div_rsp_t;

endpackage

[rtl/core/weo_front.sv]
// Decode front: takes input words and turns them into queue commands.
// Depends on weo_pkg.

module weo_front #(
  parameter int unsigned NUM_WHEELS = 2
) (
  input  logic            s_valid_i,
  output logic            s_ready_o,
  input  logic [34:0]     s_data_i,   // wheel, timestamp_ms, direction
  input  logic            s_user_i,   // operation
  input  weo_pkg::q_stat_t q_stat_i,
  output logic            q_push_o,
  output weo_pkg::cmd_t   q_cmd_o
);

  logic [weo_pkg::WheelW-1:0] wheel;
  logic [1:0]                 dcode;
  logic                       wheel_ok;

  assign wheel    = s_data_i[weo_pkg::WheelW-1:0];
  assign dcode    = s_data_i[34:33];
  assign wheel_ok = 32'(wheel) < 32'(NUM_WHEELS);

  assign s_ready_o = !q_stat_i.full;
  assign q_push_o  = s_valid_i && !q_stat_i.full;

  always_comb begin
    q_cmd_o.wheel        = wheel;
    q_cmd_o.timestamp_ms = s_data_i[32:1];
    // codes two and three both mean reverse
    q_cmd_o.dir_zero     = (dcode == 2'b00);
    q_cmd_o.dir_neg      = dcode[1];
    if (!wheel_ok) begin
      q_cmd_o.kind = weo_pkg::CMD_NO_WHEEL;
    end else if (s_user_i == weo_pkg::OP_READ) begin
      q_cmd_o.kind = weo_pkg::CMD_READ;
    end else begin
      q_cmd_o.kind = weo_pkg::CMD_PULSE;
    end
  end

endmodule

[rtl/core/weo_queue.sv]
// Short command queue between the decode front and the execution back.
// Depends on weo_pkg.

module weo_queue (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  weo_pkg::cmd_t    cmd_i,
  input  logic             pop_i,
  output weo_pkg::q_stat_t stat_o,
  output weo_pkg::cmd_t    cmd_o
);

  weo_pkg::cmd_t                      mem_q [weo_pkg::QueueDepth];
  logic [weo_pkg::QueuePtrW-1:0]      wr_ptr_q, rd_ptr_q;
  logic [weo_pkg::QueueCntW-1:0]      cnt_q;

  function automatic logic [weo_pkg::QueuePtrW-1:0] ptr_inc(
    input logic [weo_pkg::QueuePtrW-1:0] p
  );
    return (32'(p) == weo_pkg::QueueDepth - 1) ? '0 : p + 1'b1;
  endfunction

  assign stat_o.valid = (cnt_q != '0);
  assign stat_o.full  = (32'(cnt_q) == weo_pkg::QueueDepth);
  assign cmd_o        = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push_i) wr_ptr_q <= ptr_inc(wr_ptr_q);
      if (pop_i)  rd_ptr_q <= ptr_inc(rd_ptr_q);
      cnt_q <= cnt_q + weo_pkg::QueueCntW'(push_i) - weo_pkg::QueueCntW'(pop_i);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_ptr_q] <= cmd_i;
  end

endmodule

[rtl/core/weo_div.sv]
// Serial restoring divider, one quotient bit per cycle.
// Depends on weo_pkg.

module weo_div (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  weo_pkg::div_req_t req_i,
  output weo_pkg::div_rsp_t rsp_o
);

  logic [weo_pkg::DivBits-1:0] quo_q;
  logic [31:0]                 rem_q, dvs_q;
  logic [weo_pkg::DivCntW-1:0] cnt_q;
  logic                        busy_q, done_q;
  logic [32:0]                 rem_sh, diff;
  logic                        take;

  assign rem_sh = {rem_q, quo_q[weo_pkg::DivBits-1]};
  assign diff   = rem_sh - {1'b0, dvs_q};
  assign take   = !diff[32];

  assign rsp_o.done     = done_q;
  assign rsp_o.quotient = quo_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= busy_q && (cnt_q == '0);
      if (req_i.start) begin
        busy_q <= 1'b1;
        cnt_q  <= weo_pkg::DivCntW'(weo_pkg::DivBits - 1);
      end else if (busy_q) begin
        if (cnt_q == '0) busy_q <= 1'b0;
        else             cnt_q  <= cnt_q - 1'b1;
      end
    end
  end

  // Dividend bits leave at the top while quotient bits enter at the bottom
  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      quo_q <= req_i.dividend;
      rem_q <= '0;
      dvs_q <= req_i.divisor;
    end else if (busy_q) begin
      quo_q <= {quo_q[weo_pkg::DivBits-2:0], take};
      rem_q <= take ? diff[31:0] : rem_sh[31:0];
    end
  end

endmodule

[rtl/core/weo_back.sv]
// Execution back: per-wheel state, debounce and stale checks, speed
// average and the output register. Depends on weo_pkg and weo_div's interface.

module weo_back #(
  parameter int unsigned NUM_WHEELS = 2
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  weo_pkg::cfg_t     cfg_i,
  input  weo_pkg::q_stat_t  q_stat_i,
  input  weo_pkg::cmd_t     q_cmd_i,
  output logic              q_pop_o,
  output weo_pkg::div_req_t div_req_o,
  input  weo_pkg::div_rsp_t div_rsp_i,
  output logic              m_valid_o,
  input  logic              m_ready_i,
  output logic [31:0]       m_count_o,
  output logic [31:0]       m_speed_o,
  output logic              m_accepted_o
);

  localparam int unsigned NumEntries =
      (NUM_WHEELS < weo_pkg::WheelSpan) ? NUM_WHEELS : weo_pkg::WheelSpan;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHECK,
    ST_DIV,
    ST_MIX,
    ST_COMMIT,
    ST_EMIT
  } state_e;

  state_e               state_q;
  weo_pkg::cmd_t        cmd_q;
  logic signed [26:0]   sample_q, sample_d;
  logic signed [40:0]   sum_q, sum_d;
  logic [31:0]          res_cnt_q, res_spd_q;
  logic                 res_acc_q;
  logic                 out_valid_q, out_acc_q;
  logic [31:0]          out_cnt_q, out_spd_q;

  logic [31:0]          cnt_q  [NumEntries];
  logic [31:0]          spd_q  [NumEntries];
  logic [31:0]          last_q [NumEntries];

  logic [31:0]          cur_cnt, cur_spd, cur_last, delta, next_cnt, new_spd;
  logic                 debounce_ok, stale, wr_commit, wr_clear;
  logic signed [40:0]   old_ext, adj, mixed;
  logic [40:0]          bias;

  always_comb begin
    cur_cnt  = '0;
    cur_spd  = '0;
    cur_last = '0;
    for (int i = 0; i < NumEntries; i++) begin
      if (cmd_q.wheel == weo_pkg::WheelW'(i)) begin
        cur_cnt  = cnt_q[i];
        cur_spd  = spd_q[i];
        cur_last = last_q[i];
      end
    end
  end

  // Time differences wrap modulo 2^32
  assign delta       = cmd_q.timestamp_ms - cur_last;
  assign debounce_ok = delta > {24'b0, cfg_i.debounce_ms};
  assign stale       = delta > {16'b0, cfg_i.stale_ms};

  assign q_pop_o = (state_q == ST_IDLE) && q_stat_i.valid;

  assign div_req_o.start    = (state_q == ST_CHECK) && (cmd_q.kind == weo_pkg::CMD_PULSE)
                              && debounce_ok;
  assign div_req_o.dividend = weo_pkg::DivBits'(cfg_i.distance_um) * weo_pkg::MsPerSec;
  assign div_req_o.divisor  = delta;

  always_comb begin
    if (cmd_q.dir_zero)     sample_d = '0;
    else if (cmd_q.dir_neg) sample_d = -$signed({1'b0, div_rsp_i.quotient});
    else                    sample_d = $signed({1'b0, div_rsp_i.quotient});
  end

  // (2^s - 1) * old + sample, then divide by 2^s rounding toward zero
  assign old_ext = $signed({{9{cur_spd[31]}}, cur_spd});
  assign sum_d   = (old_ext <<< cfg_i.speed_shift) - old_ext
                   + $signed({{14{sample_q[26]}}, sample_q});
  assign bias    = {33'b0, (8'd1 << cfg_i.speed_shift) - 8'd1};
  assign adj     = sum_q[40] ? sum_q + $signed(bias) : sum_q;
  assign mixed   = adj >>> cfg_i.speed_shift;
  assign new_spd = mixed[31:0];

  always_comb begin
    if (cmd_q.dir_zero)     next_cnt = cur_cnt;
    else if (cmd_q.dir_neg) next_cnt = cur_cnt - 32'd1;
    else                    next_cnt = cur_cnt + 32'd1;
  end

  assign wr_commit = (state_q == ST_COMMIT);
  assign wr_clear  = (state_q == ST_CHECK) && (cmd_q.kind == weo_pkg::CMD_READ) && stale;

  for (genvar g = 0; g < NumEntries; g++) begin : g_wheel
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        cnt_q[g]  <= '0;
        spd_q[g]  <= '0;
        last_q[g] <= '0;
      end else if (cmd_q.wheel == weo_pkg::WheelW'(g)) begin
        if (wr_commit) begin
          cnt_q[g]  <= next_cnt;
          spd_q[g]  <= new_spd;
          last_q[g] <= cmd_q.timestamp_ms;
        end else if (wr_clear) begin
          spd_q[g] <= '0;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (q_pop_o) cmd_q <= q_cmd_i;
    if (state_q == ST_DIV && div_rsp_i.done) sample_q <= sample_d;
    if (state_q == ST_MIX) sum_q <= sum_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      res_cnt_q   <= '0;
      res_spd_q   <= '0;
      res_acc_q   <= 1'b0;
      out_valid_q <= 1'b0;
      out_cnt_q   <= '0;
      out_spd_q   <= '0;
      out_acc_q   <= 1'b0;
    end else begin
      if (state_q == ST_EMIT && (!out_valid_q || m_ready_i)) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && m_ready_i) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        ST_IDLE: begin
          if (q_stat_i.valid) state_q <= ST_CHECK;
        end
        ST_CHECK: begin
          res_acc_q <= 1'b0;
          unique case (cmd_q.kind)
            weo_pkg::CMD_PULSE: begin
              res_cnt_q <= cur_cnt;
              res_spd_q <= cur_spd;
              state_q   <= debounce_ok ? ST_DIV : ST_EMIT;
            end
            weo_pkg::CMD_READ: begin
              res_cnt_q <= cur_cnt;
              res_spd_q <= stale ? 32'd0 : cur_spd;
              state_q   <= ST_EMIT;
            end
            default: begin
              res_cnt_q <= '0;
              res_spd_q <= '0;
              state_q   <= ST_EMIT;
            end
          endcase
        end
        ST_DIV: begin
          if (div_rsp_i.done) state_q <= ST_MIX;
        end
        ST_MIX: begin
          state_q <= ST_COMMIT;
        end
        ST_COMMIT: begin
          res_cnt_q <= next_cnt;
          res_spd_q <= new_spd;
          res_acc_q <= 1'b1;
          state_q   <= ST_EMIT;
        end
        ST_EMIT: begin
          // hold until the output register is free or being emptied
          if (!out_valid_q || m_ready_i) begin
            out_cnt_q   <= res_cnt_q;
            out_spd_q   <= res_spd_q;
            out_acc_q   <= res_acc_q;
            state_q     <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign m_valid_o    = out_valid_q;
  assign m_count_o    = out_cnt_q;
  assign m_speed_o    = out_spd_q;
  assign m_accepted_o = out_acc_q;

endmodule

[rtl/core/wheel_encoder_odometry_unit.sv]
// Top level of the wheel encoder odometry block: configuration registers,
// decode front, command queue, serial divider and execution back.
// Depends on weo_pkg, weo_front, weo_queue, weo_div, weo_back.
//
//   channel | dir | tdata (low bit up)                         | tuser
//   s_axis  | in  | wheel, timestamp_ms[31:0], direction[1:0]  | operation
//   m_axis  | out | position_count[31:0], speed_um_per_s[31:0] | pulse_accepted
//   cfg     | in  | cfg_idx_i selects register, cfg_wdata_i    | -
//
// A counted pulse passes the back end through check, the 26-step serial
// divider, mix, commit and emit; reads and rejected pulses go from check to emit.
// Items are executed one at a time; a two-entry command queue keeps input
// open while the back end works or its output word waits on m_axis_tready.
// Reset is asynchronous, active low, and clears all wheel state at once.

module wheel_encoder_odometry_unit #(
  parameter int unsigned NUM_WHEELS = 2
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [15:0] cfg_wdata_i,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [39:0] s_axis_tdata,   // wheel, timestamp_ms, direction, zero pad
  input  logic        s_axis_tuser,   // operation
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [63:0] m_axis_tdata,   // position_count, speed_um_per_s
  output logic        m_axis_tuser    // pulse_accepted
);

  weo_pkg::cfg_t     cfg_q;
  weo_pkg::q_stat_t  q_stat;
  weo_pkg::cmd_t     push_cmd, head_cmd;
  weo_pkg::div_req_t div_req;
  weo_pkg::div_rsp_t div_rsp;
  logic              q_push, q_pop;
  logic [31:0]       out_cnt, out_spd;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.debounce_ms <= weo_pkg::DebounceRst;
      cfg_q.stale_ms    <= weo_pkg::StaleRst;
      cfg_q.distance_um <= weo_pkg::DistanceRst;
      cfg_q.speed_shift <= weo_pkg::ShiftRst;
    end else if (cfg_we_i) begin
      unique case (weo_pkg::cfg_idx_e'(cfg_idx_i))
        weo_pkg::CFG_DEBOUNCE: cfg_q.debounce_ms <= cfg_wdata_i[7:0];
        weo_pkg::CFG_STALE:    cfg_q.stale_ms    <= cfg_wdata_i;
        weo_pkg::CFG_DISTANCE: cfg_q.distance_um <= cfg_wdata_i;
        weo_pkg::CFG_SHIFT:    cfg_q.speed_shift <= cfg_wdata_i[2:0];
      endcase
    end
  end

  weo_front #(
    .NUM_WHEELS (NUM_WHEELS)
  ) u_front (
    .s_valid_i (s_axis_tvalid),
    .s_ready_o (s_axis_tready),
    .s_data_i  (s_axis_tdata[34:0]),
    .s_user_i  (s_axis_tuser),
    .q_stat_i  (q_stat),
    .q_push_o  (q_push),
    .q_cmd_o   (push_cmd)
  );

  weo_queue u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (q_push),
    .cmd_i  (push_cmd),
    .pop_i  (q_pop),
    .stat_o (q_stat),
    .cmd_o  (head_cmd)
  );

  weo_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  weo_back #(
    .NUM_WHEELS (NUM_WHEELS)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg_q),
    .q_stat_i     (q_stat),
    .q_cmd_i      (head_cmd),
    .q_pop_o      (q_pop),
    .div_req_o    (div_req),
    .div_rsp_i    (div_rsp),
    .m_valid_o    (m_axis_tvalid),
    .m_ready_i    (m_axis_tready),
    .m_count_o    (out_cnt),
    .m_speed_o    (out_spd),
    .m_accepted_o (m_axis_tuser)
  );

  assign m_axis_tdata = {out_spd, out_cnt};

endmodule

[rtl/core/weo_checker.sv]
// Port-level checker for the wheel encoder odometry block, bound to the top.
// Depends on weo_pkg for the queue depth.

module weo_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [63:0] m_axis_tdata,
  input logic        m_axis_tuser
);

  // queue entries, one in the back end, one in the output register
  localparam int unsigned MaxItems = weo_pkg::QueueDepth + 2;
  localparam int unsigned OutW     = $clog2(MaxItems + 1);

  logic [OutW-1:0] outstanding_q;
  logic            in_acc, out_acc;

  assign in_acc  = s_axis_tvalid && s_axis_tready;
  assign out_acc = m_axis_tvalid && m_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) outstanding_q <= '0;
    else         outstanding_q <= outstanding_q + OutW'(in_acc) - OutW'(out_acc);
  end

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
    else $error("output word changed while stalled");

  a_no_phantom: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> outstanding_q != '0)
    else $error("result shown with no item outstanding");

  a_full_stalls: assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(outstanding_q) == MaxItems |-> !s_axis_tready)
    else $error("input accepted beyond block capacity");

  a_empty_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    outstanding_q == '0 |-> s_axis_tready)
    else $error("input stalled while block is empty");

endmodule

bind wheel_encoder_odometry_unit weo_checker u_weo_checker (.*);

[tb/tb_wheel_encoder_odometry_unit.sv]
`timescale 1ns / 100ps
// Self-checking testbench for wheel_encoder_odometry_unit: pulse and read words in,
// per-wheel counter and filtered speed predicted and checked on every output word.
// Depends on weo_pkg and the RTL of the block.

module tb_wheel_encoder_odometry_unit;
  import weo_pkg::*;

  localparam int unsigned Wheels     = 2;
  localparam int unsigned CycleLimit = 400000;
  localparam int unsigned TailCycles = 60;

  typedef struct packed {
    logic [31:0] position;
    logic [31:0] speed;
    logic        accepted;
  } reading_t;

  logic        clk_i;
  logic        rst_ni;
  logic        cfg_we_i;
  logic [1:0]  cfg_idx_i;
  logic [15:0] cfg_wdata_i;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [39:0] s_axis_tdata;   // wheel, timestamp_ms, direction, zero pad
  logic        s_axis_tuser;   // operation
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [63:0] m_axis_tdata;   // position_count, speed_um_per_s
  logic        m_axis_tuser;   // pulse_accepted

  // Predicted configuration and wheel state
  logic [7:0]  debounce_q;
  logic [15:0] stale_q;
  logic [15:0] dist_q;
  logic [2:0]  shift_q;
  logic [31:0] count_q [Wheels];
  logic [31:0] speed_q [Wheels];
  logic [31:0] last_q  [Wheels];

  reading_t    pending_readings [$];
  int unsigned err_count   = 0;
  int unsigned cycle_count = 0;
  bit          calm        = 1'b0;

  wheel_encoder_odometry_unit #(
    .NUM_WHEELS(Wheels)
  ) uut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  function automatic reading_t odometry_step(op_e op, logic [WheelW-1:0] wheel,
                                             logic [31:0] now, logic [1:0] dcode);
    reading_t    r;
    logic [31:0] delta;
    longint      dir;
    longint      sample;
    longint      old;
    longint      weight;
    longint      mixed;
    r = '0;
    if (wheel >= Wheels) return r;
    // minus two counts as reverse
    dir = (dcode == 2'b01) ? 1 : ((dcode == 2'b00) ? 0 : -1);
    delta = now - last_q[wheel];
    if (op == OP_PULSE) begin
      if (delta > debounce_q) begin
        sample = (longint'(dist_q) * 1000 * dir) / longint'(delta);
        old    = longint'(signed'(speed_q[wheel]));
        weight = longint'(1) << shift_q;
        mixed  = ((weight - 1) * old + sample) / weight;
        count_q[wheel] = count_q[wheel] + 32'(dir);
        speed_q[wheel] = 32'(mixed);
        last_q[wheel]  = now;
        r.accepted = 1'b1;
      end
    end else if (delta > stale_q) begin
      speed_q[wheel] = '0;
    end
    r.position = count_q[wheel];
    r.speed    = speed_q[wheel];
    return r;
  endfunction

  task automatic flag_mismatch(string msg);
    err_count++;
    if (err_count <= 10) $display("%0t mismatch: %s", $time, msg);
  endtask

  always @(posedge clk_i) begin : check_words
    reading_t want;
    reading_t got;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got = {m_axis_tdata[31:0], m_axis_tdata[63:32], m_axis_tuser};
      if (pending_readings.size() == 0) begin
        flag_mismatch($sformatf("unexpected word pos %0d speed %0d accepted %0b",
                                signed'(got.position), signed'(got.speed), got.accepted));
      end else begin
        want = pending_readings.pop_front();
        if (got.position !== want.position || got.speed !== want.speed ||
            got.accepted !== want.accepted)
          flag_mismatch($sformatf("pos %0d/%0d speed %0d/%0d accepted %0b/%0b (exp/act)",
                                  signed'(want.position), signed'(got.position),
                                  signed'(want.speed), signed'(got.speed),
                                  want.accepted, got.accepted));
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CycleLimit) begin
      $display("tb_wheel_encoder_odometry_unit: errors");
      $finish;
    end
  end

  // Output back-pressure in random bursts
  initial begin
    m_axis_tready = 1'b1;
    forever begin
      @(negedge clk_i);
      if (!calm && $urandom_range(0, 5) == 0) begin
        m_axis_tready <= 1'b0;
        repeat ($urandom_range(1, 11)) @(negedge clk_i);
      end
      m_axis_tready <= 1'b1;
    end
  end

  task automatic send_word(op_e op, logic [WheelW-1:0] wheel, logic [31:0] stamp,
                           logic [1:0] dcode);
    @(negedge clk_i);
    if (!calm && $urandom_range(0, 3) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 11)) @(negedge clk_i);
    end
    s_axis_tdata  <= {5'd0, dcode, stamp, wheel};
    s_axis_tuser  <= op;
    s_axis_tvalid <= 1'b1;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    pending_readings.push_back(odometry_step(op, wheel, stamp, dcode));
  endtask

  // Drop valid and hold until every expected word is out
  task automatic drain();
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    while (pending_readings.size() != 0) @(posedge clk_i);
  endtask

  task automatic write_reg(cfg_idx_e idx, logic [15:0] value);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= value;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      CFG_DEBOUNCE: debounce_q = value[7:0];
      CFG_STALE:    stale_q    = value;
      CFG_DISTANCE: dist_q     = value;
      CFG_SHIFT:    shift_q    = value[2:0];
      default: ;
    endcase
  endtask

  task automatic configure(logic [7:0] deb, logic [15:0] stale, logic [15:0] travel,
                           logic [2:0] shift);
    drain();
    write_reg(CFG_DEBOUNCE, {8'd0, deb});
    write_reg(CFG_STALE, stale);
    write_reg(CFG_DISTANCE, travel);
    write_reg(CFG_SHIFT, {13'd0, shift});
  endtask

  // Mostly well-timed pulse trains and reads around the stale limit, some noise
  task automatic run_traffic(int unsigned words);
    logic [WheelW-1:0] wheel;
    logic [31:0]       gap;
    logic [1:0]        heading [Wheels];
    int unsigned       pick;
    heading[0] = 2'b01;
    heading[1] = 2'b11;
    repeat (words) begin
      pick  = $urandom_range(0, 99);
      wheel = WheelW'($urandom_range(0, Wheels - 1));
      if ($urandom_range(0, 19) == 0) heading[wheel] = 2'($urandom_range(0, 3));
      if (pick < 60) begin
        case ($urandom_range(0, 7))
          0: gap = $urandom_range(0, debounce_q);
          1: gap = debounce_q + $urandom_range(1, 20000);
          default: gap = debounce_q + $urandom_range(1, 300);
        endcase
        send_word(OP_PULSE, wheel, last_q[wheel] + gap, heading[wheel]);
      end else if (pick < 85) begin
        case ($urandom_range(0, 3))
          0: gap = stale_q;
          1: gap = stale_q + 1;
          default: gap = $urandom_range(0, stale_q + stale_q / 2 + 2);
        endcase
        send_word(OP_READ, wheel, last_q[wheel] + gap, 2'($urandom_range(0, 3)));
      end else begin
        send_word(op_e'($urandom_range(0, 1)), wheel, $urandom(),
                  2'($urandom_range(0, 3)));
      end
    end
  endtask

  task automatic test_reset_state();
    send_word(OP_READ, 1'b0, 32'd0, 2'b00);
    send_word(OP_READ, 1'b1, 32'd5, 2'b01);
  endtask

  task automatic test_debounce_window();
    send_word(OP_PULSE, 1'b0, 32'd10, 2'b01);
    send_word(OP_PULSE, 1'b0, 32'd11, 2'b01);
    send_word(OP_PULSE, 1'b1, 32'd11, 2'b10);
  endtask

  task automatic test_direction_codes();
    send_word(OP_PULSE, 1'b0, 32'd100, 2'b00);
    send_word(OP_PULSE, 1'b0, 32'd200, 2'b11);
    send_word(OP_PULSE, 1'b0, 32'd300, 2'b01);
    send_word(OP_PULSE, 1'b0, 32'd305, 2'b01);
  endtask

  task automatic test_stale_read();
    send_word(OP_READ, 1'b0, 32'd1200, 2'b00);
    send_word(OP_READ, 1'b0, 32'd1201, 2'b00);
  endtask

  task automatic test_time_wrap();
    send_word(OP_PULSE, 1'b1, 32'hFFFF_FFF0, 2'b01);
    send_word(OP_PULSE, 1'b1, 32'h0000_0005, 2'b01);
    send_word(OP_READ, 1'b1, 32'hFFFF_FFFF, 2'b11);
  endtask

  task automatic test_extreme_speed();
    configure(8'd0, 16'd65535, 16'd65535, 3'd0);
    send_word(OP_PULSE, 1'b0, last_q[0] + 32'd1, 2'b01);
    send_word(OP_PULSE, 1'b0, last_q[0] + 32'd1, 2'b10);
    configure(8'd0, 16'd65535, 16'd1, 3'd7);
    send_word(OP_PULSE, 1'b0, last_q[0] + 32'h8000_0000, 2'b01);
    send_word(OP_READ, 1'b0, last_q[0] + 32'd65535, 2'b00);
  endtask

  task automatic test_register_sweep();
    configure(8'd0, 16'd0, 16'd65535, 3'd0);
    run_traffic(130);
    configure(8'd255, 16'd65535, 16'd1, 3'd7);
    run_traffic(130);
    configure(DebounceRst, StaleRst, DistanceRst, ShiftRst);
    run_traffic(130);
    repeat (6) begin
      configure(8'($urandom_range(0, 255)), 16'($urandom_range(0, 4000)),
                16'($urandom_range(1, 65535)), 3'($urandom_range(0, 7)));
      run_traffic(130);
    end
  endtask

  task automatic test_calm_tail();
    calm = 1'b1;
    run_traffic(130);
  endtask

  initial begin
    rst_ni        = 1'b0;
    cfg_we_i      = 1'b0;
    cfg_idx_i     = CFG_DEBOUNCE;
    cfg_wdata_i   = '0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = 1'b0;
    debounce_q    = DebounceRst;
    stale_q       = StaleRst;
    dist_q        = DistanceRst;
    shift_q       = ShiftRst;
    foreach (count_q[i]) begin
      count_q[i] = '0;
      speed_q[i] = '0;
      last_q[i]  = '0;
    end
    repeat (12) @(negedge clk_i);
    rst_ni <= 1'b1;

    test_reset_state();
    test_debounce_window();
    test_direction_codes();
    test_stale_read();
    test_time_wrap();
    test_extreme_speed();
    test_register_sweep();
    test_calm_tail();

    drain();
    repeat (TailCycles) @(posedge clk_i);
    if (err_count == 0 && pending_readings.size() == 0) begin
      $display("tb_wheel_encoder_odometry_unit: clean");
    end else begin
      $display("tb_wheel_encoder_odometry_unit: errors");
    end
    $finish;
  end

endmodule

[wheel_encoder_odometry_unit.f]
rtl/core/weo_pkg.sv
rtl/core/weo_front.sv
rtl/core/weo_queue.sv
rtl/core/weo_div.sv
rtl/core/weo_back.sv
rtl/core/wheel_encoder_odometry_unit.sv
rtl/core/weo_checker.sv
tb/tb_wheel_encoder_odometry_unit.sv
